### design/gmp_pkg.sv
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types and constants of the grid maze generator.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int DEF_MAX_W          = 32;
  localparam int DEF_MAX_H          = 32;
  localparam int DEF_FRONTIER_DEPTH = 4096;

  localparam int RND_W      = 31;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic OP_START = 1'b0;

  typedef enum logic [1:0] {
    SIDE_LEFT  = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_UP    = 2'd2,
    SIDE_DOWN  = 2'd3
  } side_t;

  typedef struct packed {
    logic             operation;
    logic [RND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic       wall_opened;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [1:0] side;
    logic       frontier_empty;
  } out_item_t;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_CLR,
    DP_MARK,
    DP_DIV,
    DP_RDE,
    DP_RV1,
    DP_RV2,
    DP_CMP,
    DP_NBRD,
    DP_NBCK,
    DP_SHST,
    DP_SHIFT
  } dp_op_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic cnt_zero;
    logic opens;
    logic nb_last;
    logic shift_done;
    logic is_start;
  } dp_stat_t;

endpackage

### design/gmp_dp.sv
// ----------------------------------------------------------------------------
// gmp_dp
// Datapath: visited map, frontier list, remainder divider and result fields.
// ----------------------------------------------------------------------------
module gmp_dp #(
  parameter int MAX_W          = gmp_pkg::DEF_MAX_W,
  parameter int MAX_H          = gmp_pkg::DEF_MAX_H,
  parameter int FRONTIER_DEPTH = gmp_pkg::DEF_FRONTIER_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gmp_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [gmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  gmp_pkg::dp_op_t                     op,
  output gmp_pkg::dp_stat_t                   stat,
  output gmp_pkg::out_item_t                  out_item
);
  import gmp_pkg::*;

  localparam int XW    = $clog2(MAX_W);
  localparam int YW    = $clog2(MAX_H);
  localparam int DWW   = $clog2(MAX_W + 1);
  localparam int DHW   = $clog2(MAX_H + 1);
  localparam int CELLS = MAX_W * MAX_H;
  localparam int CAW   = $clog2(CELLS);
  localparam int AW    = $clog2(FRONTIER_DEPTH);
  localparam int CW    = $clog2(FRONTIER_DEPTH + 1);

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    side_t         side;
  } entry_t;

  function automatic logic [CAW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y);
    return CAW'(int'(y) * MAX_W + int'(x));
  endfunction

  function automatic logic [DWW-1:0] clamp_w(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return DWW'(1);
    if (int'(v) > MAX_W) return DWW'(MAX_W);
    return DWW'(v);
  endfunction

  function automatic logic [DHW-1:0] clamp_h(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return DHW'(1);
    if (int'(v) > MAX_H) return DHW'(MAX_H);
    return DHW'(v);
  endfunction

  logic [CFG_DATA_W-1:0] gw_r, gh_r;
  logic [DWW-1:0]        aw_r;
  logic [DHW-1:0]        ah_r;
  logic                  start_r;
  logic [RND_W-1:0]      rnd_r;
  logic [CW-1:0]         rem_r;
  logic [4:0]            bit_r;
  logic [CW-1:0]         cnt_r;
  logic [CAW-1:0]        caddr_r;
  entry_t                ent_r;
  logic                  v1_r;
  logic [XW-1:0]         cx_r;
  logic [YW-1:0]         cy_r;
  side_t                 nside_r;
  logic                  opened_r;
  logic [CW-1:0]         p_r;
  logic [AW-1:0]         w_r;
  logic                  rdv_r;

  logic                  vis_mem [CELLS];
  logic                  vis_rd_r;
  entry_t                fr_mem [FRONTIER_DEPTH];
  entry_t                fr_rd_r;

  logic [AW-1:0]   idx;
  logic [XW-1:0]   x2;
  logic [YW-1:0]   y2;
  logic [XW-1:0]   nx;
  logic [YW-1:0]   ny;
  logic            nb_in;
  logic [CAW-1:0]  vaddr;
  logic            vwe;
  logic            vwd;
  logic [AW-1:0]   faddr;
  logic            push;
  logic            rd_go;
  logic            shift_done;
  logic            xor_v;
  logic [CW:0]     trial;
  logic [CW:0]     trial_sub;

  assign idx        = rem_r[AW-1:0];
  assign xor_v      = v1_r ^ vis_rd_r;
  assign rd_go      = p_r < cnt_r;
  assign shift_done = !rd_go && !rdv_r;
  assign trial      = {rem_r, rnd_r[RND_W-1]};
  assign trial_sub  = trial - {1'b0, cnt_r};

  // Far cell of the chosen entry.
  always_comb begin
    x2 = ent_r.x;
    y2 = ent_r.y;
    unique case (ent_r.side)
      SIDE_LEFT:  x2 = ent_r.x - XW'(1);
      SIDE_RIGHT: x2 = ent_r.x + XW'(1);
      SIDE_UP:    y2 = ent_r.y - YW'(1);
      SIDE_DOWN:  y2 = ent_r.y + YW'(1);
    endcase
  end

  // Neighbor under test while pushing the frontier of the current cell.
  always_comb begin
    nx    = cx_r;
    ny    = cy_r;
    nb_in = 1'b0;
    unique case (nside_r)
      SIDE_LEFT: begin
        nx    = cx_r - XW'(1);
        nb_in = cx_r != '0;
      end
      SIDE_RIGHT: begin
        nx    = cx_r + XW'(1);
        nb_in = (int'(cx_r) + 1) < int'(aw_r);
      end
      SIDE_UP: begin
        ny    = cy_r - YW'(1);
        nb_in = cy_r != '0;
      end
      SIDE_DOWN: begin
        ny    = cy_r + YW'(1);
        nb_in = (int'(cy_r) + 1) < int'(ah_r);
      end
    endcase
  end

  assign push = (op == DP_NBCK) && nb_in && !vis_rd_r && (cnt_r < CW'(FRONTIER_DEPTH));

  always_comb begin
    vaddr = caddr_r;
    vwe   = 1'b0;
    vwd   = 1'b0;
    unique case (op)
      DP_CLR: begin
        vwe = 1'b1;
      end
      DP_MARK: begin
        vaddr = '0;
        vwe   = 1'b1;
        vwd   = 1'b1;
      end
      DP_RV1:  vaddr = cell_addr(fr_rd_r.x, fr_rd_r.y);
      DP_RV2:  vaddr = cell_addr(x2, y2);
      DP_CMP: begin
        vaddr = cell_addr(x2, y2);
        vwe   = xor_v;
        vwd   = 1'b1;
      end
      DP_NBRD: vaddr = cell_addr(nx, ny);
      default: vaddr = caddr_r;
    endcase
  end

  assign faddr = (op == DP_RDE) ? idx : p_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (vwe) begin
      vis_mem[vaddr] <= vwd;
    end
    vis_rd_r <= vis_mem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fr_mem[cnt_r[AW-1:0]] <= entry_t'{x: cx_r, y: cy_r, side: nside_r};
    end else if (op == DP_SHIFT && rdv_r) begin
      fr_mem[w_r] <= fr_rd_r;
    end
    fr_rd_r <= fr_mem[faddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r     <= GRID_DIM_RESET;
      gh_r     <= GRID_DIM_RESET;
      cnt_r    <= '0;
      start_r  <= 1'b0;
      opened_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_GRID_WIDTH) begin
        gw_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_GRID_HEIGHT) begin
        gh_r <= cfg_data;
      end
      unique case (op)
        DP_ACCEPT: begin
          start_r  <= in_item.operation == OP_START;
          rnd_r    <= in_item.random_value;
          rem_r    <= '0;
          bit_r    <= 5'(RND_W - 1);
          opened_r <= 1'b0;
          if (in_item.operation == OP_START) begin
            aw_r    <= clamp_w(gw_r);
            ah_r    <= clamp_h(gh_r);
            cnt_r   <= '0;
            caddr_r <= '0;
          end
        end
        DP_CLR: caddr_r <= caddr_r + CAW'(1);
        DP_MARK: begin
          cx_r    <= '0;
          cy_r    <= '0;
          nside_r <= SIDE_LEFT;
        end
        DP_DIV: begin
          rem_r <= trial_sub[CW] ? trial[CW-1:0] : trial_sub[CW-1:0];
          rnd_r <= {rnd_r[RND_W-2:0], 1'b0};
          bit_r <= bit_r - 5'd1;
        end
        DP_RV1: ent_r <= fr_rd_r;
        DP_RV2: v1_r  <= vis_rd_r;
        DP_CMP: begin
          if (xor_v) begin
            opened_r <= 1'b1;
            cx_r     <= x2;
            cy_r     <= y2;
            nside_r  <= SIDE_LEFT;
          end
        end
        DP_NBCK: begin
          if (push) begin
            cnt_r <= cnt_r + CW'(1);
          end
          nside_r <= side_t'(nside_r + 2'd1);
        end
        DP_SHST: begin
          p_r   <= CW'(idx) + CW'(1);
          w_r   <= idx;
          rdv_r <= 1'b0;
        end
        DP_SHIFT: begin
          if (rd_go) begin
            p_r <= p_r + CW'(1);
          end
          rdv_r <= rd_go;
          if (rdv_r) begin
            w_r <= w_r + AW'(1);
          end
          if (shift_done) begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.clr_last   = caddr_r == CAW'(CELLS - 1);
  assign stat.div_last   = bit_r == '0;
  assign stat.cnt_zero   = cnt_r == '0;
  assign stat.opens      = xor_v;
  assign stat.nb_last    = nside_r == SIDE_DOWN;
  assign stat.shift_done = shift_done;
  assign stat.is_start   = start_r;

  assign out_item.wall_opened    = opened_r;
  assign out_item.cell_x         = opened_r ? 5'(ent_r.x) : 5'd0;
  assign out_item.cell_y         = opened_r ? 5'(ent_r.y) : 5'd0;
  assign out_item.side           = opened_r ? ent_r.side : SIDE_LEFT;
  assign out_item.frontier_empty = cnt_r == '0;

endmodule

### design/gmp_ctrl.sv
// ----------------------------------------------------------------------------
// gmp_ctrl
// Controller: sequences the datapath through clear, divide, test, push, shift.
// ----------------------------------------------------------------------------
module gmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  input  gmp_pkg::dp_stat_t stat,
  output gmp_pkg::dp_op_t   op,
  output logic              busy,
  output logic              out_valid
);
  import gmp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MARK, S_DIV, S_RDE, S_RV1, S_RV2, S_CMP,
    S_NBRD, S_NBCK, S_SHST, S_SHIFT, S_RES
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;

  always_comb begin
    op        = DP_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          op = DP_ACCEPT;
          if (in_operation == OP_START) state_nxt = S_CLR;
          else if (stat.cnt_zero)       state_nxt = S_RES;
          else                          state_nxt = S_DIV;
        end
      end
      S_CLR: begin
        op = DP_CLR;
        if (stat.clr_last) state_nxt = S_MARK;
      end
      S_MARK: begin
        op        = DP_MARK;
        state_nxt = S_NBRD;
      end
      S_DIV: begin
        op = DP_DIV;
        if (stat.div_last) state_nxt = S_RDE;
      end
      S_RDE: begin
        op        = DP_RDE;
        state_nxt = S_RV1;
      end
      S_RV1: begin
        op        = DP_RV1;
        state_nxt = S_RV2;
      end
      S_RV2: begin
        op        = DP_RV2;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        op        = DP_CMP;
        state_nxt = stat.opens ? S_NBRD : S_SHST;
      end
      S_NBRD: begin
        op        = DP_NBRD;
        state_nxt = S_NBCK;
      end
      S_NBCK: begin
        op = DP_NBCK;
        if (stat.nb_last) state_nxt = stat.is_start ? S_RES : S_SHST;
        else              state_nxt = S_NBRD;
      end
      S_SHST: begin
        op        = DP_SHST;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        op = DP_SHIFT;
        if (stat.shift_done) state_nxt = S_RES;
      end
      S_RES: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= state_nxt != S_IDLE;
      out_valid_r <= state_nxt == S_RES;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

### design/grid_maze_prim_generator.sv
// ----------------------------------------------------------------------------
// grid_maze_prim_generator
// Randomized Prim maze generator with a frontier list in on-chip memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Operation zero
// starts a new maze on the grid size held in the configuration registers;
// operation one takes one frontier step with random_value picking the entry.
// Every transaction gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
// Busy rises at the edge that takes the transaction and falls with the result,
// so the next transaction can be taken only once the result has been shown.
// A start sweeps the visited map, marks the corner cell, tests and pushes its
// neighbors, and shows the result. A step reduces random_value bit-serially
// modulo the list length, fetches the entry and tests both cells, sets up the
// shift, shifts and shows the result. Opening a wall adds the tests and pushes
// of the new cell's neighbors. The entries behind the chosen one move down one
// place to close the gap. A step on an empty list goes straight to the result.
// Configuration writes are always taken (cfg_ready is high) and are used at
// the next start. Reset empties the frontier list and sets the grid size to
// 16 by 16.
// ----------------------------------------------------------------------------
module grid_maze_prim_generator #(
  parameter int MAX_W          = gmp_pkg::DEF_MAX_W,
  parameter int MAX_H          = gmp_pkg::DEF_MAX_H,
  parameter int FRONTIER_DEPTH = gmp_pkg::DEF_FRONTIER_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  gmp_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output gmp_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gmp_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gmp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_item.operation),
    .stat         (stat),
    .op           (op),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  gmp_dp #(
    .MAX_W          (MAX_W),
    .MAX_H          (MAX_H),
    .FRONTIER_DEPTH (FRONTIER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .stat      (stat),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after a transaction");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result longer than one cycle");

  a_open_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.wall_opened |-> $past(busy, 2))
    else $error("wall opened without a step in progress");

endmodule

### dv/grid_maze_prim_generator_tb.sv
// ----------------------------------------------------------------------------
// grid_maze_prim_generator_tb
// Self-checking testbench for the randomized Prim maze generator. A predictor
// tracks the visited map and the ordered frontier list, and works out the
// result of every accepted transaction. Results are compared field by field.
// Stimulus runs through several grid sizes, including out-of-range register
// values. The sender idles in random bursts and gaps.
// ----------------------------------------------------------------------------
module grid_maze_prim_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gmp_pkg::*;

  localparam int GRID_MAX   = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam logic OP_STEP  = 1'b1;

  typedef struct {
    logic [4:0] x;
    logic [4:0] y;
    side_t      side;
  } frontier_entry_t;

  class maze_scoreboard;
    logic [5:0]      reg_w = GRID_DIM_RESET;
    logic [5:0]      reg_h = GRID_DIM_RESET;
    int              live_w = 16;
    int              live_h = 16;
    bit              visited[GRID_MAX*GRID_MAX];
    frontier_entry_t frontier[$];
    out_item_t       expected_q[$];
    int              errors = 0;

    task flag(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [5:0] val);
      if (idx == CFG_GRID_WIDTH) reg_w = val;
      else if (idx == CFG_GRID_HEIGHT) reg_h = val;
    endfunction

    function int clamp_dim(logic [5:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function void append_entry(frontier_entry_t e);
      frontier = {frontier, e};
    endfunction

    function void push_open_sides(int x, int y);
      frontier_entry_t e;
      e.x = 5'(x);
      e.y = 5'(y);
      if (x >= 1 && !visited[y*GRID_MAX + x - 1]) begin
        e.side = SIDE_LEFT; append_entry(e);
      end
      if (x + 1 < live_w && !visited[y*GRID_MAX + x + 1]) begin
        e.side = SIDE_RIGHT; append_entry(e);
      end
      if (y >= 1 && !visited[(y-1)*GRID_MAX + x]) begin
        e.side = SIDE_UP; append_entry(e);
      end
      if (y + 1 < live_h && !visited[(y+1)*GRID_MAX + x]) begin
        e.side = SIDE_DOWN; append_entry(e);
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t       r;
      frontier_entry_t e;
      int unsigned     idx;
      int              x2, y2;
      r = '0;
      if (it.operation == OP_START) begin
        live_w = clamp_dim(reg_w);
        live_h = clamp_dim(reg_h);
        foreach (visited[i]) visited[i] = 0;
        frontier.delete();
        visited[0] = 1;
        push_open_sides(0, 0);
      end else if (frontier.size() != 0) begin
        idx = it.random_value % frontier.size();
        e = frontier[idx];
        x2 = e.x;
        y2 = e.y;
        case (e.side)
          SIDE_LEFT:  x2 = e.x - 1;
          SIDE_RIGHT: x2 = e.x + 1;
          SIDE_UP:    y2 = e.y - 1;
          default:    y2 = e.y + 1;
        endcase
        if (visited[e.y*GRID_MAX + e.x] != visited[y2*GRID_MAX + x2]) begin
          visited[y2*GRID_MAX + x2] = 1;
          r.wall_opened = 1;
          r.cell_x = e.x;
          r.cell_y = e.y;
          r.side = e.side;
          push_open_sides(x2, y2);
        end
        frontier.delete(idx);
      end
      r.frontier_empty = (frontier.size() == 0);
      expected_q = {expected_q, r};
    endfunction

    task check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        flag("result with no transaction outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (got.wall_opened !== exp.wall_opened)
        flag($sformatf("wall_opened %0b exp %0b", got.wall_opened, exp.wall_opened));
      if (got.cell_x !== exp.cell_x)
        flag($sformatf("cell_x %0d exp %0d", got.cell_x, exp.cell_x));
      if (got.cell_y !== exp.cell_y)
        flag($sformatf("cell_y %0d exp %0d", got.cell_y, exp.cell_y));
      if (got.side !== exp.side)
        flag($sformatf("side %0d exp %0d", got.side, exp.side));
      if (got.frontier_empty !== exp.frontier_empty)
        flag($sformatf("frontier_empty %0b exp %0b", got.frontier_empty,
                       exp.frontier_empty));
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  start = 0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  maze_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  grid_maze_prim_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Any accepted transaction on either side counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task send(logic op, logic [RND_W-1:0] rnd);
    in_item_t it;
    it.operation = op;
    it.random_value = rnd;
    start <= 1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 12);
    end
  endtask

  task drain;
    start <= 0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [5:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [RND_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RND_W'($urandom());
    endcase
  endfunction

  initial begin
    int dims[8][2] = '{'{0, 1}, '{63, 2}, '{2, 63}, '{3, 3}, '{32, 32},
                       '{8, 4}, '{5, 12}, '{1, 40}};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: step on an empty list before any start, then the default grid.
    send(OP_STEP, '1);
    send(OP_START, '1);
    send(OP_STEP, '0);
    send(OP_STEP, '1);
    send(OP_STEP, 31'h5555_5555);
    send(OP_STEP, 31'h2AAA_AAAA);
    send(OP_STEP, 31'd1);
    repeat (8) send(OP_STEP, rand_value());
    send(OP_START, '0);
    repeat (6) send(OP_STEP, rand_value());
    drain();

    foreach (dims[p]) begin
      write_cfg(CFG_GRID_WIDTH, 6'(dims[p][0]));
      write_cfg(CFG_GRID_HEIGHT, 6'(dims[p][1]));
      // On odd phases the old maze keeps going under the new register values.
      if (p % 2 == 0) send(OP_START, rand_value());
      repeat (33) begin
        if ($urandom_range(0, 24) == 0) send(OP_START, rand_value());
        else send(OP_STEP, rand_value());
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
